>>> hdl/smfa_pkg.sv
// ----------------------------------------------------------------------------
// smfa_pkg
// shared widths, codes and request types of the sign-magnitude fixed alu
// ----------------------------------------------------------------------------
package smfa_pkg;

    localparam int MAG_WIDTH  = 31;
    localparam int SUM_WIDTH  = MAG_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;
    localparam int SHIFT_W    = 5;
    localparam int CNT_W      = 7;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUL_MODE  = 2'd2;

    // reset values
    localparam logic [SHIFT_W-1:0] FRAC_BITS_RST = 5'd15;
    localparam logic [SHIFT_W-1:0] INT_BITS_RST  = 5'd15;
    localparam logic               MUL_MODE_RST  = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [MAG_WIDTH-1:0] a_mag;
        logic                 a_neg;
        logic [MAG_WIDTH-1:0] b_mag;
        logic                 b_neg;
    } t_in_req;

    typedef struct packed {
        logic [MAG_WIDTH-1:0] r_mag;
        logic                 r_neg;
        logic                 saturated;
    } t_out_req;

endpackage

>>> hdl/smfa_if.sv
// ----------------------------------------------------------------------------
// smfa interfaces
// valid/ready channels for operand requests, result requests and config writes
// ----------------------------------------------------------------------------
interface smfa_in_if;
    logic             valid;
    logic             ready;
    smfa_pkg::t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smfa_out_if;
    logic              valid;
    logic              ready;
    smfa_pkg::t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [smfa_pkg::CFG_IDX_W-1:0]  index;
    logic [smfa_pkg::CFG_DATA_W-1:0] value;
    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

>>> hdl/sign_magnitude_fixed_alu_unit.sv
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_alu_unit
// three-stage pipelined sign-magnitude fixed-point alu with saturation
// ----------------------------------------------------------------------------
// The unit takes one request per cycle on i_in when the output side does not
// stall and returns exactly one result request per operand request, in order,
// on o_out after stage 3 registers it. Stage 1 decodes the operation,
// applies the half-fraction pre-shift of multiply mode 0 and forms the
// saturation limit; stage 2 holds the single 31x31 multiplier and the
// add/subtract with magnitude compare; stage 3 applies the full-product
// shift of mode 1, compares against the limit and registers the result.
// Each stage holds one request and a valid bit and moves on whenever the
// stage after it is empty or moving, so a stall at o_out fills the pipe
// and then drops i_in.ready; nothing is lost or repeated. Configuration
// writes on i_cfg are always taken and should be issued only while the
// pipe is empty; indexes beyond mul_mode are ignored.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_alu_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    smfa_in_if.sink         i_in,
    smfa_out_if.source      o_out,
    smfa_cfg_if.sink        i_cfg
);

    // configuration registers
    logic [smfa_pkg::SHIFT_W-1:0] r_frac_bits;
    logic [smfa_pkg::SHIFT_W-1:0] r_int_bits;
    logic                         r_mul_mode;

    // per-stage readiness: a stage loads when it is empty or its content moves on
    logic w_rdy1, w_rdy2, w_rdy3;

    // stage 1 registers
    logic                           r_v1;
    logic [smfa_pkg::MAG_WIDTH-1:0] r_s1_a, r_s1_b;
    logic                           r_s1_an, r_s1_bn;
    logic                           r_s1_mul, r_s1_mode;
    logic [smfa_pkg::SHIFT_W-1:0]   r_s1_frac;
    logic [smfa_pkg::MAG_WIDTH-1:0] r_s1_lim;

    // stage 2 registers
    logic                            r_v2;
    logic [smfa_pkg::PROD_WIDTH-1:0] r_s2_val;
    logic                            r_s2_neg;
    logic                            r_s2_shift;
    logic [smfa_pkg::SHIFT_W-1:0]    r_s2_frac;
    logic [smfa_pkg::MAG_WIDTH-1:0]  r_s2_lim;
    logic                            r_s2_mul;

    // stage 3 (output) registers
    logic                           r_v3;
    logic [smfa_pkg::MAG_WIDTH-1:0] r_s3_mag;
    logic                           r_s3_neg;
    logic                           r_s3_sat;
    logic [smfa_pkg::MAG_WIDTH-1:0] r_s3_lim;
    logic                           r_s3_mul;
    logic                           r_s3_zero;

    // stage 1 combinational
    logic                           n_s1_mul;
    logic                           n_s1_bn;
    logic [smfa_pkg::SHIFT_W-1:0]   w_half;
    logic [smfa_pkg::SHIFT_W-1:0]   w_half_a;
    logic [smfa_pkg::MAG_WIDTH-1:0] n_s1_a, n_s1_b;
    logic [smfa_pkg::CNT_W-1:0]     w_bits;
    logic [smfa_pkg::MAG_WIDTH-1:0] n_s1_lim;

    // stage 2 combinational
    logic [smfa_pkg::PROD_WIDTH-1:0] w_prod;
    logic [smfa_pkg::SUM_WIDTH-1:0]  w_sum;
    logic                            w_sum_neg;
    logic [smfa_pkg::PROD_WIDTH-1:0] n_s2_val;
    logic                            n_s2_neg;

    // stage 3 combinational
    logic [smfa_pkg::PROD_WIDTH-1:0] w_shifted;
    logic                            n_s3_sat;
    logic [smfa_pkg::MAG_WIDTH-1:0]  n_s3_mag;

    // ---------------------------------------------------------------- handshake
    assign w_rdy3      = !r_v3 || o_out.ready;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_in.ready  = w_rdy1;
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------ configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= smfa_pkg::FRAC_BITS_RST;
            r_int_bits  <= smfa_pkg::INT_BITS_RST;
            r_mul_mode  <= smfa_pkg::MUL_MODE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                smfa_pkg::REG_FRAC_BITS: r_frac_bits <= i_cfg.value;
                smfa_pkg::REG_INT_BITS:  r_int_bits  <= i_cfg.value;
                smfa_pkg::REG_MUL_MODE:  r_mul_mode  <= i_cfg.value[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------ stage 1
    always_comb begin
        // only bit 1 selects multiply, so the unused code runs as multiply
        n_s1_mul = i_in.data.cmd[1];
        n_s1_bn  = i_in.data.b_neg ^ (i_in.data.cmd == smfa_pkg::CMD_SUB);

        // mode 0 pre-shift: half the fraction bits each, the odd bit on a
        w_half   = r_frac_bits >> 1;
        w_half_a = w_half + {{(smfa_pkg::SHIFT_W-1){1'b0}}, r_frac_bits[0]};
        if (n_s1_mul && !r_mul_mode) begin
            n_s1_a = i_in.data.a_mag >> w_half_a;
            n_s1_b = i_in.data.b_mag >> w_half;
        end else begin
            n_s1_a = i_in.data.a_mag;
            n_s1_b = i_in.data.b_mag;
        end

        // limit 2^(int+frac)-1, capped at full magnitude width
        w_bits = smfa_pkg::CNT_W'(r_int_bits) + smfa_pkg::CNT_W'(r_frac_bits);
        if (w_bits >= smfa_pkg::CNT_W'(smfa_pkg::MAG_WIDTH)) begin
            n_s1_lim = '1;
        end else begin
            n_s1_lim = {smfa_pkg::MAG_WIDTH{1'b1}}
                       >> (smfa_pkg::CNT_W'(smfa_pkg::MAG_WIDTH) - w_bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_a    <= n_s1_a;
            r_s1_b    <= n_s1_b;
            r_s1_an   <= i_in.data.a_neg;
            r_s1_bn   <= n_s1_mul ? i_in.data.b_neg : n_s1_bn;
            r_s1_mul  <= n_s1_mul;
            r_s1_mode <= r_mul_mode;
            r_s1_frac <= r_frac_bits;
            r_s1_lim  <= n_s1_lim;
        end
    end

    // ------------------------------------------------------------------ stage 2
    always_comb begin
        w_prod = smfa_pkg::PROD_WIDTH'(r_s1_a) * smfa_pkg::PROD_WIDTH'(r_s1_b);

        // signed sum of two sign-magnitude values
        if (r_s1_an == r_s1_bn) begin
            w_sum     = smfa_pkg::SUM_WIDTH'(r_s1_a) + smfa_pkg::SUM_WIDTH'(r_s1_b);
            w_sum_neg = r_s1_an;
        end else if (r_s1_a >= r_s1_b) begin
            w_sum     = smfa_pkg::SUM_WIDTH'(r_s1_a - r_s1_b);
            w_sum_neg = r_s1_an;
        end else begin
            w_sum     = smfa_pkg::SUM_WIDTH'(r_s1_b - r_s1_a);
            w_sum_neg = r_s1_bn;
        end

        if (r_s1_mul) begin
            n_s2_val = w_prod;
            n_s2_neg = r_s1_an ^ r_s1_bn;
        end else begin
            n_s2_val = smfa_pkg::PROD_WIDTH'(w_sum);
            // a zero sum is positive
            n_s2_neg = (w_sum == '0) ? 1'b0 : w_sum_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_val   <= n_s2_val;
            r_s2_neg   <= n_s2_neg;
            r_s2_shift <= r_s1_mul && r_s1_mode;
            r_s2_frac  <= r_s1_frac;
            r_s2_lim   <= r_s1_lim;
            r_s2_mul   <= r_s1_mul;
        end
    end

    // ------------------------------------------------------------------ stage 3
    always_comb begin
        // mode 1: drop fraction bits of the full product
        w_shifted = r_s2_shift ? (r_s2_val >> r_s2_frac) : r_s2_val;
        n_s3_sat  = w_shifted > smfa_pkg::PROD_WIDTH'(r_s2_lim);
        n_s3_mag  = n_s3_sat ? r_s2_lim : w_shifted[smfa_pkg::MAG_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_mag  <= n_s3_mag;
            r_s3_neg  <= r_s2_neg;
            r_s3_sat  <= n_s3_sat;
            r_s3_lim  <= r_s2_lim;
            r_s3_mul  <= r_s2_mul;
            r_s3_zero <= (r_s2_val == '0);
        end
    end

    assign o_out.valid          = r_v3;
    assign o_out.data.r_mag     = r_s3_mag;
    assign o_out.data.r_neg     = r_s3_neg;
    assign o_out.data.saturated = r_s3_sat;

`ifndef SYNTHESIS
    // a clamped result carries exactly the limit
    a_sat_is_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_s3_sat |-> r_s3_mag == r_s3_lim)
        else $error("saturated result differs from limit");

    // an unclamped result never exceeds the limit
    a_mag_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_s3_sat |-> r_s3_mag <= r_s3_lim)
        else $error("unsaturated result above limit");

    // a zero add/subtract result is positive
    a_zero_sum_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_s3_mul && r_s3_zero |-> !r_s3_neg)
        else $error("zero sum has negative sign");

    // input back-pressure only when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_rdy1 |-> r_v1 && r_v2 && r_v3 && !o_out.ready)
        else $error("input stalled with room in the pipe");

    // a stalled output request holds its magnitude and saturated flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !o_out.ready |=> r_v3 && $stable(r_s3_mag) && $stable(r_s3_sat))
        else $error("stalled result changed");
`endif

endmodule
